// ===== rtl/core/newton_integer_square_root_macros.svh =====
`ifndef NEWTON_INTEGER_SQUARE_ROOT_MACROS_SVH
`define NEWTON_INTEGER_SQUARE_ROOT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ISR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ISR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/isr_pkg.sv =====
`timescale 1ns / 1ps

package isr_pkg;

    localparam int DATA_WIDTH = 32;
    // datapath width without the sign bit of the signed original
    localparam int DW         = DATA_WIDTH - 1;
    localparam int IW         = 31;
    localparam int XW         = (DW > IW) ? DW : IW;
    localparam int MAX_ROUNDS = 4 * DATA_WIDTH + 8;
    localparam int RND_W      = $clog2(MAX_ROUNDS + 1);
    localparam int CNT_W      = $clog2(DW + 1);

    typedef struct packed {
        logic load;
        logic div_start;
        logic upd;
    } cmd_t;

    typedef struct packed {
        logic gt_ba;
        logic gt_ab;
        logic div_done;
    } sts_t;

endpackage

// ===== rtl/core/isr_div.sv =====
`timescale 1ns / 1ps

module isr_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [isr_pkg::DW-1:0] dividend,
    input  logic [isr_pkg::DW-1:0] divisor,
    output logic                done,
    output logic [isr_pkg::DW-1:0] quotient
);
    import isr_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    den_reg, den_next;

    logic [DW:0]      shifted;
    logic [DW:0]      diff;
    logic             ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DW-1]};
        diff      = shifted - {1'b0, den_reg};
        ge        = (shifted >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    // zero divisor gives zero
    assign quotient = (den_reg == '0) ? '0 : quo_reg;

endmodule

// ===== rtl/core/isr_dp.sv =====
`timescale 1ns / 1ps

module isr_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  isr_pkg::cmd_t          cmd,
    input  logic [isr_pkg::IW-1:0] radicand,
    output isr_pkg::sts_t          sts,
    output logic [isr_pkg::IW-1:0] root
);
    import isr_pkg::*;

    logic [DW-1:0] n_reg, n_next;
    logic [DW-1:0] a_reg, a_next;
    logic [DW-1:0] b_reg, b_next;

    logic [XW-1:0] rad_ext;
    logic [XW-1:0] root_ext;
    logic [DW-1:0] n_in;
    logic [DW:0]   init_sum;
    logic [DW:0]   upd_sum;
    logic [DW-1:0] q;
    logic          div_done;

    isr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (n_reg),
        .divisor  (a_reg),
        .done     (div_done),
        .quotient (q)
    );

    always_comb
    begin
        rad_ext  = XW'(radicand);
        n_in     = rad_ext[DW-1:0];
        init_sum = {1'b0, n_in} + (DW+1)'(1);
        upd_sum  = {1'b0, a_reg} + {1'b0, q};
        n_next   = n_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        if (cmd.load)
        begin
            n_next = n_in;
            b_next = n_in;
            a_next = init_sum[DW:1];
        end
        else if (cmd.upd)
        begin
            b_next = q;
            a_next = upd_sum[DW:1];
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    // guard bit keeps x + 1 from wrapping
    assign sts.gt_ba    = ({1'b0, b_reg} > ({1'b0, a_reg} + (DW+1)'(1)));
    assign sts.gt_ab    = ({1'b0, a_reg} > ({1'b0, b_reg} + (DW+1)'(1)));
    assign sts.div_done = div_done;

    assign root_ext = XW'(a_reg);
    assign root     = root_ext[IW-1:0];

endmodule

// ===== rtl/core/isr_ctrl.sv =====
`timescale 1ns / 1ps

module isr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          out_stall,
    input  isr_pkg::sts_t sts,
    output logic          in_stall,
    output logic          out_valid,
    output isr_pkg::cmd_t cmd
);
    import isr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK1,
        S_DIV1,
        S_CHK2,
        S_DIV2,
        S_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [RND_W-1:0] rounds_reg, rounds_next;
    logic             in_stall_reg, in_stall_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        rounds_next   = rounds_reg;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    rounds_next = '0;
                    state_next  = S_CHK1;
                end
            end
            S_CHK1:
            begin
                if (rounds_reg == RND_W'(MAX_ROUNDS))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    rounds_next = rounds_reg + 1'b1;
                    if (sts.gt_ba)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV1;
                    end
                    else
                    begin
                        state_next = S_CHK2;
                    end
                end
            end
            S_DIV1:
            begin
                if (sts.div_done)
                begin
                    cmd.upd    = 1'b1;
                    state_next = S_CHK2;
                end
            end
            S_CHK2:
            begin
                if (sts.gt_ab)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV2;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV2:
            begin
                if (sts.div_done)
                begin
                    cmd.upd    = 1'b1;
                    state_next = S_CHK1;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        in_stall_next  = (state_next != S_IDLE);
        out_valid_next = (state_next == S_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rounds_reg    <= '0;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rounds_reg    <= rounds_next;
            in_stall_reg  <= in_stall_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/newton_integer_square_root.sv =====
// An update is one or two state checks, DATA_WIDTH - 1 divider steps and the divider's done flag.
// One item at a time; the next item can be taken in the cycle after the result is delivered.
// Reset: rst_n asynchronous, active low; clears control state, block comes up idle.
`timescale 1ns / 1ps

`include "newton_integer_square_root_macros.svh"

module newton_integer_square_root (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [isr_pkg::IW-1:0] radicand,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [isr_pkg::IW-1:0] root
);
    import isr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    isr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    isr_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .radicand (radicand),
        .sts      (sts),
        .root     (root)
    );

    `ISR_ASSERT_NOW(a_load_on_accept, cmd.load, in_valid && !in_stall, "load without accepted item")
    `ISR_ASSERT_NOW(a_upd_needs_quot, cmd.upd, sts.div_done, "update before quotient ready")
    `ISR_ASSERT_NOW(a_no_cmd_in_out, out_valid, !cmd.upd && !cmd.div_start, "datapath busy with result shown")
    `ISR_ASSERT_NEXT(a_start_not_done, cmd.div_start, !sts.div_done, "divider finished too early")

endmodule

// ===== tb/newton_integer_square_root_tb.sv =====
`timescale 1ns / 1ps

module newton_integer_square_root_tb;

    import isr_pkg::*;

    localparam int  CLK_PERIOD   = 10;
    localparam int  RESET_CYCLES = 7;
    localparam int  DRAIN_CYCLES = 1000;
    localparam longint CYCLE_LIMIT = 5_000_000;
    // root of the largest exact square that still fits in the radicand field
    localparam int  TOP_ROOT     = 46340;

    typedef struct {
        logic [IW-1:0] radicand;
        logic [IW-1:0] root;
    } root_check_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [IW-1:0] radicand = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [IW-1:0] root;

    logic [IW-1:0] radicand_queue[$];
    root_check_t   root_expect[$];

    int     accepted_count = 0;
    int     delivered_count = 0;
    int     error_count = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    longint cycle_count = 0;

    newton_integer_square_root uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .radicand  (radicand),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .root      (root)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Babylonian iteration with a guard bit; loop order matters since the
    // answer can land one above the floor.
    function automatic logic [IW-1:0] newton_root(input logic [IW-1:0] value);
        logic [63:0] n;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] width_mask;
        int          rounds;
        bit          converged;
        width_mask = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
        n = 64'(value) & width_mask;
        b = n;
        a = (b + 64'd1) >> 1;
        rounds = 0;
        converged = 1'b0;
        while (!converged && rounds < MAX_ROUNDS)
        begin
            rounds++;
            if (b > a + 64'd1)
            begin
                b = (a == 64'd0) ? 64'd0 : n / a;
                a = (a + b) >> 1;
            end
            if (a > b + 64'd1)
            begin
                b = (a == 64'd0) ? 64'd0 : n / a;
                a = (a + b) >> 1;
            end
            else
            begin
                converged = 1'b1;
            end
        end
        return a[IW-1:0];
    endfunction

    task automatic queue_radicand(input logic [IW-1:0] value);
        root_check_t entry;
        entry.radicand = value;
        entry.root = newton_root(value);
        radicand_queue.push_back(value);
        root_expect.push_back(entry);
    endtask

    // Full-width values and random bit lengths so small and large radicands both show up,
    // plus values hugging exact squares where floor vs floor+1 flips.
    function automatic logic [IW-1:0] random_radicand();
        logic [63:0] value;
        int          pick;
        int          bits;
        int          base;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            value = 64'($urandom);
        end
        else if (pick < 65)
        begin
            bits = $urandom_range(0, IW);
            value = 64'($urandom) & ((64'd1 << bits) - 64'd1);
        end
        else
        begin
            base = $urandom_range(0, TOP_ROOT);
            value = 64'(base) * 64'(base) + 64'($urandom_range(0, 2));
            if (value != 64'd0)
            begin
                value = value - 64'd1;
            end
        end
        return value[IW-1:0];
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        while (radicand_queue.size() != 0 || in_valid || delivered_count != accepted_count)
        begin
            @(negedge clk);
        end
    endtask

    task automatic random_phase(input int count, input int idle, input int stall);
        @(negedge clk);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            queue_radicand(random_radicand());
        end
        // sender holds off at the end until every root is back
        wait_idle();
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            radicand <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                accepted_count <= accepted_count + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (radicand_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    radicand <= radicand_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        root_check_t entry;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (delivered_count >= accepted_count || root_expect.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, got root %0d", $time, root);
                    error_count++;
                end
                else
                begin
                    entry = root_expect.pop_front();
                    if (root !== entry.root)
                    begin
                        $display("%0t: root mismatch for radicand %0d: expected %0d, got %0d",
                                 $time, entry.radicand, entry.root, root);
                        error_count++;
                    end
                end
                delivered_count <= delivered_count + 1;
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d roots outstanding", $time, root_expect.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [IW-1:0] all_ones;
        all_ones = '1;
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero, tiny values, floor+1 answers, top of range, near-top squares
        queue_radicand('0);
        queue_radicand(IW'(1));
        queue_radicand(IW'(2));
        queue_radicand(IW'(3));
        queue_radicand(IW'(4));
        queue_radicand(IW'(5));
        queue_radicand(IW'(8));
        queue_radicand(IW'(15));
        queue_radicand(IW'(16));
        queue_radicand(IW'(24));
        queue_radicand(IW'(25));
        queue_radicand(IW'(26));
        queue_radicand(IW'(99));
        queue_radicand(IW'(65535));
        queue_radicand(IW'(65536));
        queue_radicand(all_ones);
        queue_radicand(all_ones - IW'(1));
        queue_radicand(IW'(1) << (IW - 1));
        queue_radicand((IW'(1) << (IW - 1)) - IW'(1));
        queue_radicand(IW'(TOP_ROOT * TOP_ROOT));
        queue_radicand(IW'(TOP_ROOT * TOP_ROOT - 1));
        queue_radicand(IW'(TOP_ROOT * TOP_ROOT + 1));
        queue_radicand(IW'(32'h5555_5555));
        queue_radicand(IW'(32'h2AAA_AAAA));
        wait_idle();

        random_phase(210, 0, 0);
        random_phase(205, 58, 0);
        random_phase(205, 0, 58);
        random_phase(210, 24, 24);

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d roots: zero, small values, exact squares and neighbors, full range,",
                 delivered_count);
        $display("under free-running, sender-idle, receiver-stall and mixed handshake phases.");
        if (error_count == 0 && root_expect.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
